/* design/psba_pkg.sv */
// Package for the per-station byte aggregator.
// Holds field widths, action codes, status codes and CSR indices; no dependencies.
package psba_pkg;

   localparam int ADDR_W   = 48;
   localparam int TOTAL_W  = 32;
   localparam int LEN_W    = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int PREFIX_W = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_MERGED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_DROPPED = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ENTRY   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_CLEARED = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_RECEIVER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_ONLY     = 1'd1;

endpackage

/* design/psba_store.sv */
// Entry store for the per-station byte aggregator: key and total per entry.
// One write port, one read port with registered read data; no package use.
module psba_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 80
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/per_station_byte_aggregator_top.sv */
// Top level of the per-station byte aggregator: sequencer, compare/add unit.
// Depends on psba_pkg and psba_store.
// A record on an empty table is answered straight from idle; else the sequencer searches
// the entries, one key compare per cycle through the store's read port.
// A dump answers with one entry per cycle; a clear is answered straight from idle.
// Busy drops with the final result; nothing stalls a transaction.
// Synchronous active-high reset empties the table and zeroes both registers.
module per_station_byte_aggregator_top #(
   parameter int ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [psba_pkg::ACTION_W-1:0]      req_action,
   input  logic [psba_pkg::ADDR_W-1:0]        req_transmitter_address,
   input  logic [psba_pkg::ADDR_W-1:0]        req_receiver_address,
   input  logic [psba_pkg::LEN_W-1:0]         req_packet_length,
   output logic                               rsp_valid,
   output logic [psba_pkg::STATUS_W-1:0]      rsp_status,
   output logic [psba_pkg::ADDR_W-1:0]        rsp_entry_address,
   output logic [psba_pkg::TOTAL_W-1:0]       rsp_entry_total,
   output logic                               rsp_last,
   input  logic                               csr_write_enable,
   input  logic [psba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psba_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int DATA_W = psba_pkg::ADDR_W + psba_pkg::TOTAL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DUMP
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          sel_rx_ff, sel_rx_in;
   logic                          prefix_ff, prefix_in;
   logic [psba_pkg::ADDR_W-1:0]   key_ff, key_in;
   logic [psba_pkg::LEN_W-1:0]    len_ff, len_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [psba_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [psba_pkg::TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [DATA_W-1:0]             wr_data;
   logic [IDX_W-1:0]              rd_addr;
   logic [DATA_W-1:0]             rd_data;

   logic [psba_pkg::ADDR_W-1:0]   rd_key;
   logic [psba_pkg::TOTAL_W-1:0]  rd_total;
   logic [psba_pkg::ADDR_W-1:0]   req_key;
   logic [psba_pkg::TOTAL_W:0]    sum;
   logic [psba_pkg::TOTAL_W-1:0]  sat_sum;
   logic                          at_end;
   logic                          accept;

   psba_store #(
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign rd_key   = rd_data[DATA_W-1 -: psba_pkg::ADDR_W];
   assign rd_total = rd_data[psba_pkg::TOTAL_W-1:0];
   assign sum      = {1'b0, rd_total} + (psba_pkg::TOTAL_W + 1)'(len_ff);
   assign sat_sum  = sum[psba_pkg::TOTAL_W] ? '1 : sum[psba_pkg::TOTAL_W-1:0];
   assign at_end   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      req_key = sel_rx_ff ? req_receiver_address : req_transmitter_address;
      if (prefix_ff) begin
         req_key[psba_pkg::ADDR_W-psba_pkg::PREFIX_W-1:0] = '0;
      end
   end

   // present the next entry while the current one sits in the read register
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : idx_ff + IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      sel_rx_in     = sel_rx_ff;
      prefix_in     = prefix_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = {key_ff, psba_pkg::TOTAL_W'(len_ff)};

      if (csr_write_enable) begin
         case (csr_index)
            psba_pkg::CSR_SELECT_RECEIVER: sel_rx_in = csr_write_data[0];
            psba_pkg::CSR_PREFIX_ONLY:     prefix_in = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_key;
               len_in = req_packet_length;
               idx_in = '0;
               case (req_action)
                  psba_pkg::ACT_RECORD: begin
                     if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = {req_key, psba_pkg::TOTAL_W'(req_packet_length)};
                        count_in      = CNT_W'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = psba_pkg::STS_ADDED;
                        rsp_addr_in   = req_key;
                        rsp_total_in  = psba_pkg::TOTAL_W'(req_packet_length);
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  psba_pkg::ACT_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = psba_pkg::STS_EMPTY;
                        rsp_addr_in   = '0;
                        rsp_total_in  = '0;
                     end else begin
                        state_in = ST_DUMP;
                     end
                  end
                  psba_pkg::ACT_CLEAR: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = psba_pkg::STS_CLEARED;
                     rsp_addr_in   = '0;
                     rsp_total_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            rsp_addr_in = key_ff;
            if (rd_key == key_ff) begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               wr_data       = {key_ff, sat_sum};
               rsp_valid_in  = 1'b1;
               rsp_status_in = psba_pkg::STS_MERGED;
               rsp_total_in  = sat_sum;
               state_in      = ST_IDLE;
            end else if (at_end) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff < CNT_W'(ENTRIES)) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_status_in = psba_pkg::STS_ADDED;
                  rsp_total_in  = psba_pkg::TOTAL_W'(len_ff);
               end else begin
                  rsp_status_in = psba_pkg::STS_DROPPED;
                  rsp_total_in  = '0;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DUMP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = psba_pkg::STS_ENTRY;
            rsp_addr_in   = rd_key;
            rsp_total_in  = rd_total;
            rsp_last_in   = at_end;
            if (at_end) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         sel_rx_ff    <= 1'b0;
         prefix_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         sel_rx_ff    <= sel_rx_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      key_ff        <= key_in;
      len_ff        <= len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_address = rsp_addr_ff;
   assign rsp_entry_total   = rsp_total_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table size");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> state_ff == ST_IDLE)
      else $error("final transaction result while sequencer still active");

   a_record_progress: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == psba_pkg::ACT_RECORD |=> busy || rsp_valid_ff)
      else $error("record transaction neither searched nor answered");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == psba_pkg::STS_DROPPED
         |-> count_ff == CNT_W'(ENTRIES))
      else $error("key dropped while table not full");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for per_station_byte_aggregator_top.
// Depends on psba_pkg and the aggregator RTL; keeps its own model of the station
// list and checks every result against it, in order.
`timescale 1ns / 100ps

module tb_top;

   localparam int STATION_SLOTS = 64;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int RANDOM_ITEMS  = 67;

   localparam int ACTION_W   = psba_pkg::ACTION_W;
   localparam int ADDR_W     = psba_pkg::ADDR_W;
   localparam int LEN_W      = psba_pkg::LEN_W;
   localparam int STATUS_W   = psba_pkg::STATUS_W;
   localparam int TOTAL_W    = psba_pkg::TOTAL_W;
   localparam int PREFIX_W   = psba_pkg::PREFIX_W;
   localparam int CSR_IDX_W  = psba_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = psba_pkg::CSR_DATA_W;

   localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;
   localparam logic [ADDR_W-1:0]   PREFIX_MASK   =
      {{PREFIX_W{1'b1}}, {(ADDR_W-PREFIX_W){1'b0}}};

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   tx_addr;
      logic [ADDR_W-1:0]   rx_addr;
      logic [LEN_W-1:0]    length;
   } packet_txn_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
      logic [TOTAL_W-1:0]  total;
      logic                last;
   } station_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ACTION_W-1:0]   req_action = '0;
   logic [ADDR_W-1:0]     req_transmitter_address = '0;
   logic [ADDR_W-1:0]     req_receiver_address = '0;
   logic [LEN_W-1:0]      req_packet_length = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_entry_address;
   logic [TOTAL_W-1:0]    rsp_entry_total;
   logic                  rsp_last;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   packet_txn_type     queued_packets[$];
   station_report_type awaited_reports[$];

   logic [ADDR_W-1:0]  station_keys[STATION_SLOTS];
   logic [TOTAL_W-1:0] station_totals[STATION_SLOTS];
   int                 station_count = 0;
   logic               sel_receiver_q = 1'b0;
   logic               prefix_only_q = 1'b0;

   logic [ADDR_W-1:0]  address_pool[16];
   int                 sender_idle_pct = 0;
   logic               req_taken = 1'b0;
   packet_txn_type     drive_pkt;
   packet_txn_type     sampled_pkt;
   station_report_type got_report;
   station_report_type want_report;

   int cycle_count = 0;
   int error_count = 0;
   int accepted_count = 0;
   int results_checked = 0;
   int saturated_merges = 0;
   int status_seen[8] = '{default: 0};

   per_station_byte_aggregator_top #(
      .ENTRIES(STATION_SLOTS)
   ) i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_action              (req_action),
      .req_transmitter_address (req_transmitter_address),
      .req_receiver_address    (req_receiver_address),
      .req_packet_length       (req_packet_length),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_entry_address       (rsp_entry_address),
      .rsp_entry_total         (rsp_entry_total),
      .rsp_last                (rsp_last),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic push_report(input logic [STATUS_W-1:0] status,
                              input logic [ADDR_W-1:0] addr,
                              input logic [TOTAL_W-1:0] total, input logic last);
      station_report_type r;
      r.status = status;
      r.addr   = addr;
      r.total  = total;
      r.last   = last;
      awaited_reports.push_back(r);
   endtask

   task automatic account_packet(input packet_txn_type pkt);
      logic [ADDR_W-1:0] key;
      logic [TOTAL_W:0]  sum;
      int                hit;
      int                i;
      hit = -1;
      if (pkt.action == psba_pkg::ACT_RECORD) begin
         key = sel_receiver_q ? pkt.rx_addr : pkt.tx_addr;
         if (prefix_only_q) key = key & PREFIX_MASK;
         for (i = 0; i < station_count; i++)
            if (hit < 0 && station_keys[i] == key) hit = i;
         if (hit >= 0) begin
            sum = {1'b0, station_totals[hit]} + (TOTAL_W + 1)'(pkt.length);
            if (sum[TOTAL_W]) begin
               sum = {1'b0, {TOTAL_W{1'b1}}};
               saturated_merges++;
            end
            station_totals[hit] = sum[TOTAL_W-1:0];
            push_report(psba_pkg::STS_MERGED, key, sum[TOTAL_W-1:0], 1'b1);
         end else if (station_count < STATION_SLOTS) begin
            station_keys[station_count]   = key;
            station_totals[station_count] = {{(TOTAL_W-LEN_W){1'b0}}, pkt.length};
            station_count++;
            push_report(psba_pkg::STS_ADDED, key, {{(TOTAL_W-LEN_W){1'b0}}, pkt.length},
                        1'b1);
         end else begin
            push_report(psba_pkg::STS_DROPPED, key, '0, 1'b1);
         end
      end else if (pkt.action == psba_pkg::ACT_DUMP) begin
         if (station_count == 0)
            push_report(psba_pkg::STS_EMPTY, '0, '0, 1'b1);
         else
            for (i = 0; i < station_count; i++)
               push_report(psba_pkg::STS_ENTRY, station_keys[i], station_totals[i],
                           i == station_count - 1);
      end else if (pkt.action == psba_pkg::ACT_CLEAR) begin
         station_count = 0;
         push_report(psba_pkg::STS_CLEARED, '0, '0, 1'b1);
      end
   endtask

   // Advance to the next transaction once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (queued_packets.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            drive_pkt = queued_packets.pop_front();
            req_action              <= drive_pkt.action;
            req_transmitter_address <= drive_pkt.tx_addr;
            req_receiver_address    <= drive_pkt.rx_addr;
            req_packet_length       <= drive_pkt.length;
            start                   <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken = 1'b0;
      if (reset) begin
         station_count  = 0;
         sel_receiver_q = 1'b0;
         prefix_only_q  = 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == psba_pkg::CSR_SELECT_RECEIVER)
               sel_receiver_q = csr_write_data[0];
            else if (csr_index == psba_pkg::CSR_PREFIX_ONLY)
               prefix_only_q = csr_write_data[0];
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            accepted_count++;
            sampled_pkt.action  = req_action;
            sampled_pkt.tx_addr = req_transmitter_address;
            sampled_pkt.rx_addr = req_receiver_address;
            sampled_pkt.length  = req_packet_length;
            account_packet(sampled_pkt);
         end
         if (rsp_valid) begin
            results_checked++;
            got_report.status = rsp_status;
            got_report.addr   = rsp_entry_address;
            got_report.total  = rsp_entry_total;
            got_report.last   = rsp_last;
            status_seen[rsp_status]++;
            if (awaited_reports.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: status %0d addr %h total %0d last %0d",
                           got_report.status, got_report.addr, got_report.total,
                           got_report.last);
            end else begin
               want_report = awaited_reports.pop_front();
               if (got_report.status !== want_report.status ||
                   got_report.addr !== want_report.addr ||
                   got_report.total !== want_report.total ||
                   got_report.last !== want_report.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch at cycle %0d: expected %0d/%h/%0d/%0d",
                               " got %0d/%h/%0d/%0d"},
                              cycle_count, want_report.status, want_report.addr,
                              want_report.total, want_report.last, got_report.status,
                              got_report.addr, got_report.total, got_report.last);
               end
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic queue_packet(input logic [ACTION_W-1:0] action,
                               input logic [ADDR_W-1:0] tx_addr,
                               input logic [ADDR_W-1:0] rx_addr,
                               input logic [LEN_W-1:0] length);
      packet_txn_type p;
      p.action  = action;
      p.tx_addr = tx_addr;
      p.rx_addr = rx_addr;
      p.length  = length;
      queued_packets.push_back(p);
   endtask

   function automatic logic [ADDR_W-1:0] any_address();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return address_pool[$urandom_range(0, 15)];
      if (pick == 6) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return any_address();
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return LEN_W'($urandom_range(0, 65535));
   endfunction

   task automatic queue_random_packets(input int count);
      int                  taken;
      int                  pick;
      logic [ACTION_W-1:0] action;
      taken = 0;
      while (taken < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) action = ACT_UNDEFINED;
         else if (pick < 6) action = psba_pkg::ACT_CLEAR;
         else if (pick < 13) action = psba_pkg::ACT_DUMP;
         else action = psba_pkg::ACT_RECORD;
         queue_packet(action, pick_address(), pick_address(), pick_length());
         if (action != ACT_UNDEFINED) taken++;
      end
   endtask

   // Hold until every transaction is sent and answered, then let the block settle.
   task automatic drain_block();
      while (queued_packets.size() != 0 || start || awaited_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [PREFIX_W-1:0] prefixes[4];
      int                  i;
      for (i = 0; i < 4; i++) prefixes[i] = PREFIX_W'($urandom());
      for (i = 0; i < 16; i++)
         address_pool[i] = {prefixes[i % 4], 24'($urandom())};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_register(psba_pkg::CSR_SELECT_RECEIVER, 1'b0);
      write_register(psba_pkg::CSR_PREFIX_ONLY, 1'b0);
      sender_idle_pct = 13;
      queue_packet(psba_pkg::ACT_DUMP, '0, '0, '0);
      queue_packet(psba_pkg::ACT_CLEAR, '0, '0, '0);
      queue_packet(psba_pkg::ACT_RECORD, '0, '1, '0);
      queue_packet(psba_pkg::ACT_RECORD, '1, '0, '1);
      queue_packet(psba_pkg::ACT_RECORD, '0, 48'h1234_5678_9ABC, '1);
      queue_packet(ACT_UNDEFINED, any_address(), any_address(), pick_length());
      queue_packet(psba_pkg::ACT_RECORD, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'hAAAA);
      queue_packet(psba_pkg::ACT_RECORD, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'h5555);
      queue_packet(psba_pkg::ACT_DUMP, '0, '0, '0);
      queue_packet(psba_pkg::ACT_CLEAR, '0, '0, '0);
      queue_packet(psba_pkg::ACT_DUMP, '0, '0, '0);
      // Fill every slot, then push one key past the end and merge into a full list.
      for (i = 0; i < STATION_SLOTS; i++)
         queue_packet(psba_pkg::ACT_RECORD, {i[7:0], 40'h13_579B_DF02}, any_address(),
                      pick_length());
      queue_packet(psba_pkg::ACT_RECORD, {8'hFF, 40'h13_579B_DF02}, any_address(),
                   pick_length());
      queue_packet(psba_pkg::ACT_RECORD, {8'h00, 40'h13_579B_DF02}, any_address(),
                   pick_length());
      queue_packet(psba_pkg::ACT_DUMP, '0, '0, '0);
      queue_packet(psba_pkg::ACT_CLEAR, '0, '0, '0);
      drain_block();

      write_register(psba_pkg::CSR_SELECT_RECEIVER, 1'b1);
      queue_random_packets(RANDOM_ITEMS);
      drain_block();

      write_register(psba_pkg::CSR_SELECT_RECEIVER, 1'b0);
      write_register(psba_pkg::CSR_PREFIX_ONLY, 1'b1);
      sender_idle_pct = 53;
      queue_random_packets(RANDOM_ITEMS);
      drain_block();

      write_register(psba_pkg::CSR_SELECT_RECEIVER, 1'b1);
      sender_idle_pct = 0;
      queue_random_packets(RANDOM_ITEMS);
      drain_block();

      $display("Covered %0d transactions, %0d results checked in %0d cycles:",
               accepted_count, results_checked, cycle_count);
      $display("  %0d added, %0d merged (%0d saturating), %0d dropped,",
               status_seen[psba_pkg::STS_ADDED], status_seen[psba_pkg::STS_MERGED],
               saturated_merges, status_seen[psba_pkg::STS_DROPPED]);
      $display("  %0d dumped, %0d empty, %0d cleared",
               status_seen[psba_pkg::STS_ENTRY], status_seen[psba_pkg::STS_EMPTY],
               status_seen[psba_pkg::STS_CLEARED]);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* per_station_byte_aggregator_top.f */
design/psba_pkg.sv
design/psba_store.sv
design/per_station_byte_aggregator_top.sv
verif/tb_top.sv
